/* rtl/quoted_printable_decoder_assert.svh */
// Assertion macros used by the quoted-printable decoder checker.
`ifndef QUOTED_PRINTABLE_DECODER_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define QPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define QPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/qpd_pkg.sv */
// Types, character codes and phase codes of the quoted-printable decoder.
package qpd_pkg;

  localparam logic [7:0] CharEq = 8'h3D;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

  // Decode phase codes.
  localparam logic [2:0] PhPlain   = 3'd0;
  localparam logic [2:0] PhEq      = 3'd1;
  localparam logic [2:0] PhHex2    = 3'd2;
  localparam logic [2:0] PhCr      = 3'd3;
  localparam logic [2:0] PhDiscard = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       message_end;
    logic       bad_escape;
  } result_t;

  // {ok, value}: ok is 0 when c is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* rtl/qpd_in_stage.sv */
// Input register of the quoted-printable decoder.
module qpd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  qpd_pkg::item_t  item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output qpd_pkg::item_t  item_o
);

  logic           valid_q, valid_d;
  qpd_pkg::item_t item_q;
  logic           load;

  // Loads when the register is empty or the held request moves on.
  assign load = in_valid_i && (!valid_q || advance_i);

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/qpd_core.sv */
// Decode logic and phase state of the quoted-printable decoder.
module qpd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qpd_pkg::item_t    item_i,
  input  logic              fire_i,
  output logic              has_res_o,
  output qpd_pkg::result_t  res_o
);

  logic [2:0] phase_q, phase_d;
  logic [3:0] nib_q, nib_d;
  logic [2:0] eff;
  logic [4:0] hx;
  logic [7:0] c;
  logic       fin;

  assign c   = item_i.in_byte;
  assign fin = item_i.is_final;
  assign hx  = qpd_pkg::hex_digit(c);
  // After '=' CR, anything but LF is treated as plain text.
  assign eff = (phase_q == qpd_pkg::PhCr) ? qpd_pkg::PhPlain : phase_q;

  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    has_res_o = 1'b0;
    res_o     = '0;
    if (phase_q == qpd_pkg::PhCr && c == qpd_pkg::CharLf) begin
      phase_d           = qpd_pkg::PhPlain;
      has_res_o         = fin;
      res_o.message_end = 1'b1;
    end else begin
      unique case (eff)
        qpd_pkg::PhEq: begin
          if (fin) begin
            has_res_o         = 1'b1;
            res_o.message_end = 1'b1;
            phase_d           = qpd_pkg::PhPlain;
          end else if (c == qpd_pkg::CharCr) begin
            phase_d = qpd_pkg::PhCr;
          end else if (c == qpd_pkg::CharLf) begin
            phase_d = qpd_pkg::PhPlain;
          end else if (!hx[4]) begin
            has_res_o        = 1'b1;
            res_o.bad_escape = 1'b1;
            phase_d          = qpd_pkg::PhDiscard;
          end else begin
            nib_d   = hx[3:0];
            phase_d = qpd_pkg::PhHex2;
          end
        end
        qpd_pkg::PhHex2: begin
          has_res_o         = 1'b1;
          res_o.message_end = fin;
          nib_d             = 4'd0;
          if (!hx[4]) begin
            res_o.bad_escape = 1'b1;
            phase_d          = qpd_pkg::PhDiscard;
          end else begin
            res_o.out_byte   = {nib_q, hx[3:0]};
            res_o.byte_valid = 1'b1;
            phase_d          = qpd_pkg::PhPlain;
          end
        end
        qpd_pkg::PhDiscard: begin
          has_res_o         = fin;
          res_o.message_end = 1'b1;
        end
        default: begin
          if (c == qpd_pkg::CharEq) begin
            has_res_o         = fin;
            res_o.message_end = 1'b1;
            phase_d           = qpd_pkg::PhEq;
          end else begin
            has_res_o         = 1'b1;
            res_o.out_byte    = c;
            res_o.byte_valid  = 1'b1;
            res_o.message_end = fin;
            phase_d           = qpd_pkg::PhPlain;
          end
        end
      endcase
    end
    if (fin) begin
      phase_d = qpd_pkg::PhPlain;
      nib_d   = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qpd_pkg::PhPlain;
      nib_q   <= 4'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
    end
  end

endmodule

/* rtl/qpd_out_stage.sv */
// Result register of the quoted-printable decoder.
module qpd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  qpd_pkg::result_t  res_i,
  input  logic              out_stall_i,
  output logic              free_o,
  output logic              out_valid_o,
  output qpd_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  qpd_pkg::result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/quoted_printable_decoder.sv */
// Top level of the quoted-printable decoder: input register, decode, result register.
//
// Usage:
//   Input channel carries one encoded byte per request (in_byte_i) plus
//   is_final_i on the last byte of a message. Output channel carries at most
//   one result per input byte: a decoded byte (byte_valid_o), an error flag
//   (bad_escape_o) and message_end_o on the result of the last byte.
//   A request moves when valid is high and stall is low on its channel.
// Path: a byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle while the output is not stalled; the decode phase
//   register is updated once per byte by combinational logic, which sets this rate.
//   Bytes that give no result (escape introducers, soft line breaks,
//   discarded bytes) pass through without waiting for output space.
// Reset: asynchronous, active low; both stages empty, phase back to plain
//   text.
// Output stall: the result register holds its request; the input register
//   keeps taking bytes, and stalls the sender once it holds one that needs
//   the output.
module quoted_printable_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       message_end_o,
  output logic       bad_escape_o
);

  qpd_pkg::item_t   in_item, s1_item;
  qpd_pkg::result_t dec_res, out_res;
  logic             s1_valid;
  logic             has_res;
  logic             out_free;
  logic             s1_go;

  assign in_item.in_byte  = in_byte_i;
  assign in_item.is_final = is_final_i;

  // Held byte moves on when it needs no output slot, or one is free.
  assign s1_go      = s1_valid && (!has_res || out_free);
  assign in_stall_o = s1_valid && !s1_go;

  qpd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .item_i    (in_item),
    .advance_i (s1_go),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  qpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (s1_item),
    .fire_i   (s1_go),
    .has_res_o(has_res),
    .res_o    (dec_res)
  );

  qpd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s1_go && has_res),
    .res_i      (dec_res),
    .out_stall_i(out_stall_i),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .res_o      (out_res)
  );

  assign out_byte_o    = out_res.out_byte;
  assign byte_valid_o  = out_res.byte_valid;
  assign message_end_o = out_res.message_end;
  assign bad_escape_o  = out_res.bad_escape;

endmodule

/* rtl/qpd_checker.sv */
// Port-level checker for the quoted-printable decoder, bound to the top level.
`include "quoted_printable_decoder_assert.svh"

module qpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       is_final_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       message_end_o,
  input logic       bad_escape_o
);

  `QPD_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i) && $stable(is_final_i), "request changed while stalled")
  `QPD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `QPD_ASSERT(a_err_no_byte, out_valid_o |-> !(byte_valid_o && bad_escape_o), "byte and error")
  `QPD_ASSERT(a_zero_byte, out_valid_o && !byte_valid_o |-> out_byte_o == 8'd0, "stray data byte")
  `QPD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result shown in reset")

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (.*);

/* tb/sv/tb_quoted_printable_decoder.sv */
// Self-checking testbench for the quoted-printable decoder top level.
`timescale 1ns / 1ps

module tb_quoted_printable_decoder;

  // Idle cycles waited after the last owed result is back.
  localparam int DrainCycles = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       is_final_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       message_end_o;
  logic       bad_escape_o;

  quoted_printable_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .is_final_i   (is_final_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .message_end_o(message_end_o),
    .bad_escape_o (bad_escape_o)
  );

  always #5 clk_i = ~clk_i;

  // Decoder state mirrored by the predictor.
  logic [2:0] model_phase = qpd_pkg::PhPlain;
  logic [3:0] model_nibble = 4'h0;

  // Results owed by the block, oldest first.
  qpd_pkg::result_t pending_results[$];

  int idle_pct = 0;     // sender gap chance, percent
  int stall_pct = 0;    // receiver stall chance, percent
  int hold_request = 0; // long receiver hold-off, in cycles, picked up below
  int hold_left = 0;

  int errors = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int results_seen = 0;
  int decoded_seen = 0;
  int bad_seen = 0;

  // Value of a hex digit, or -1 for anything else.
  function automatic int hex_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  // Digit for a nibble, case picked at random for letters.
  function automatic logic [7:0] hex_char(input int n);
    if (n < 10) return 8'(8'h30 + n);
    return ($urandom_range(0, 1) == 0) ? 8'(8'h41 + n - 10) : 8'(8'h61 + n - 10);
  endfunction

  function automatic void owe_result(input logic [7:0] b, input logic bv,
                                     input logic fin, input logic bad);
    qpd_pkg::result_t r;
    r.out_byte    = bv ? b : 8'h00;
    r.byte_valid  = bv;
    r.message_end = fin;
    r.bad_escape  = bad;
    pending_results.push_back(r);
  endfunction

  // Advance the mirrored decoder by one accepted byte and queue any result.
  function automatic void decode_byte(input logic [7:0] c, input logic fin);
    logic [2:0] ph;
    logic       done;
    int         h;
    ph = model_phase;
    done = 1'b0;
    // After "=" CR: an LF completes the soft break, anything else is plain text.
    if (ph == qpd_pkg::PhCr) begin
      ph = qpd_pkg::PhPlain;
      if (c == qpd_pkg::CharLf) begin
        if (fin) owe_result(8'h00, 1'b0, 1'b1, 1'b0);
        done = 1'b1;
      end
    end
    if (!done) begin
      case (ph)
        qpd_pkg::PhEq: begin
          if (fin) begin
            // Escape cut short by end of message.
            owe_result(8'h00, 1'b0, 1'b1, 1'b0);
            ph = qpd_pkg::PhPlain;
          end else if (c == qpd_pkg::CharCr) begin
            ph = qpd_pkg::PhCr;
          end else if (c == qpd_pkg::CharLf) begin
            ph = qpd_pkg::PhPlain;
          end else begin
            h = hex_value(c);
            if (h < 0) begin
              owe_result(8'h00, 1'b0, 1'b0, 1'b1);
              ph = qpd_pkg::PhDiscard;
            end else begin
              model_nibble = 4'(h);
              ph = qpd_pkg::PhHex2;
            end
          end
        end
        qpd_pkg::PhHex2: begin
          h = hex_value(c);
          if (h < 0) begin
            owe_result(8'h00, 1'b0, fin, 1'b1);
            ph = qpd_pkg::PhDiscard;
          end else begin
            owe_result({model_nibble, 4'(h)}, 1'b1, fin, 1'b0);
            ph = qpd_pkg::PhPlain;
          end
          model_nibble = 4'h0;
        end
        qpd_pkg::PhDiscard: begin
          if (fin) owe_result(8'h00, 1'b0, 1'b1, 1'b0);
        end
        default: begin
          if (c == qpd_pkg::CharEq) begin
            if (fin) owe_result(8'h00, 1'b0, 1'b1, 1'b0);
            else ph = qpd_pkg::PhEq;
          end else begin
            owe_result(c, 1'b1, fin, 1'b0);
            ph = qpd_pkg::PhPlain;
          end
        end
      endcase
    end
    if (fin) begin
      ph = qpd_pkg::PhPlain;
      model_nibble = 4'h0;
    end
    model_phase = ph;
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      errors++;
    end
  endfunction

  // Result checker: every accepted result against the oldest owed one.
  always @(posedge clk_i) begin
    qpd_pkg::result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (byte_valid_o) decoded_seen++;
      if (bad_escape_o) bad_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_byte 0x%0h byte_valid %0b end %0b bad %0b",
               out_byte_o, byte_valid_o, message_end_o, bad_escape_o);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        check_field("out_byte", exp.out_byte, out_byte_o);
        check_field("byte_valid", exp.byte_valid, byte_valid_o);
        check_field("message_end", exp.message_end, message_end_o);
        check_field("bad_escape", exp.bad_escape, bad_escape_o);
      end
    end
  end

  // One request on the input channel, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_final_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, fin);
    bytes_sent++;
    if (fin) messages_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed text with escapes and soft breaks, some noise.
  task automatic send_random_message();
    logic [7:0] msg[$];
    logic [7:0] c;
    int         goal;
    int         pick;
    goal = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    while (msg.size() < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        msg.push_back(c == qpd_pkg::CharEq ? 8'h3E : c);
      end else if (pick < 70) begin
        msg.push_back(qpd_pkg::CharEq);
        msg.push_back(hex_char($urandom_range(0, 15)));
        msg.push_back(hex_char($urandom_range(0, 15)));
      end else if (pick < 80) begin
        msg.push_back(qpd_pkg::CharEq);
        case ($urandom_range(0, 2))
          0: begin
            msg.push_back(qpd_pkg::CharCr);
            msg.push_back(qpd_pkg::CharLf);
          end
          1: msg.push_back(qpd_pkg::CharLf);
          default: msg.push_back(qpd_pkg::CharCr);
        endcase
      end else if (pick < 85) begin
        // Broken escape, bad digit in first or second place.
        msg.push_back(qpd_pkg::CharEq);
        if ($urandom_range(0, 1) == 1) msg.push_back(hex_char($urandom_range(0, 15)));
        do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
        msg.push_back(c);
      end else begin
        msg.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_message(msg);
  endtask

  task automatic send_random_bytes(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_message();
  endtask

  // Extremes, each escape form and special cases of the decoder.
  task automatic test_directed();
    // 0x00, 0xFF, "=9a", "=F0", "=" LF, trailing "=" on the last byte
    send_message('{8'h00, 8'hFF, qpd_pkg::CharEq, "9", "a", qpd_pkg::CharEq, "F", "0",
                   qpd_pkg::CharEq, qpd_pkg::CharLf, qpd_pkg::CharEq});
    // "=" CR LF, "=" CR followed by "=" handled as plain, "=41" ending the message
    send_message('{qpd_pkg::CharEq, qpd_pkg::CharCr, qpd_pkg::CharLf, qpd_pkg::CharEq,
                   qpd_pkg::CharCr, qpd_pkg::CharEq, "4", "1"});
    // Bad first digit, rest of the message discarded
    send_message('{qpd_pkg::CharEq, "G", "q", "r"});
    // Bad second digit on the last byte
    send_message('{qpd_pkg::CharEq, "4", "g"});
    // "=" as the next-to-last byte swallows the last one
    send_message('{qpd_pkg::CharEq, "x"});
    wait_drained();
  endtask

  task automatic test_random_phase(input int sender_gap, input int receiver_gap,
                                   input int count);
    idle_pct  = sender_gap;
    stall_pct = receiver_gap;
    send_random_bytes(count);
  endtask

  // Receiver holds off while the sender keeps offering plain bytes.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_request = 200;
    for (int i = 0; i < 40; i++) send_byte(8'(8'h41 + i % 26), i == 39);
  endtask

  // Sender stops until every owed result is in, then carries on.
  task automatic test_sender_pause();
    idle_pct  = 10;
    stall_pct = 30;
    send_random_bytes(60);
    wait_drained();
    send_random_bytes(60);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phase(0, 0, 250);
    test_random_phase(69, 0, 250);
    test_random_phase(0, 69, 250);
    test_random_phase(29, 29, 250);
    test_backpressure();
    test_sender_pause();
    test_random_phase(0, 0, 80);
    wait_drained();
    $display("Covered %0d bytes in %0d messages under idle, stall and hold-off pressure.",
             bytes_sent, messages_sent);
    $display("Checked %0d results: %0d decoded bytes, %0d bad escapes.",
             results_seen, decoded_seen, bad_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still owed.", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qpd_pkg.sv
rtl/qpd_in_stage.sv
rtl/qpd_core.sv
rtl/qpd_out_stage.sv
rtl/quoted_printable_decoder.sv
rtl/qpd_checker.sv
tb/sv/tb_quoted_printable_decoder.sv
